// ===== rtl/gbb_pkg.sv =====
// Shared types, constants and helpers of the bitmap glyph blitter.
`timescale 1ns / 1ps
package gbb_pkg;

  localparam int GLYPH_HEIGHT = 16;
  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_COUNT  = 256;

  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(GLYPH_HEIGHT);

  localparam int CODE_W   = 8;
  localparam int GROW_W   = 4;
  localparam int BITS_W   = 8;
  localparam int TROW_W   = 9;
  localparam int TCOL_W   = 10;
  localparam int COLOR_W  = 32;
  localparam int ADDR_W   = 26;
  localparam int MASK_W   = 8;
  localparam int WIDTH_W  = 14;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  localparam int IN_CODE_LSB  = 0;
  localparam int IN_GROW_LSB  = IN_CODE_LSB + CODE_W;
  localparam int IN_BITS_LSB  = IN_GROW_LSB + GROW_W;
  localparam int IN_TROW_LSB  = IN_BITS_LSB + BITS_W;
  localparam int IN_TCOL_LSB  = IN_TROW_LSB + TROW_W;
  localparam int IN_COLOR_LSB = IN_TCOL_LSB + TCOL_W;

  localparam int OUT_ADDR_LSB  = 0;
  localparam int OUT_MASK_LSB  = OUT_ADDR_LSB + ADDR_W;
  localparam int OUT_COLOR_LSB = OUT_MASK_LSB + MASK_W;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);

  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_RUN
  } gbb_state_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [STORE_AW-1:0] addr;
    logic [BITS_W-1:0]   wdata;
  } gbb_mem_req_t;

  function automatic logic [MASK_W-1:0] row_mask(input logic [BITS_W-1:0] bits);
    logic [MASK_W-1:0] m;
    int                b;
    m = '0;
    for (int x = 0; x < MASK_W; x++) begin
      b = GLYPH_WIDTH - 1 - x;
      if (x < GLYPH_WIDTH && b >= 0 && b < BITS_W) begin
        m[MASK_W-1-x] = bits[b[2:0]];
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/bitmap_glyph_blitter_core.sv =====
// Top level of the bitmap glyph blitter: width register, sequencer and glyph store.
//
//  channel | direction | handshake            | payload
//  in_     | in        | in_tvalid/in_tready  | in_tdata, in_tuser
//  out_    | out       | out_tvalid/out_tready| out_tdata, out_tlast
//  cfg_    | in        | cfg_valid/cfg_ready  | cfg_data (surface width)
//
// A load word writes the glyph store directly, in the cycle it is accepted.
// A draw word is accepted, the base address multiply runs in ST_BASE, then one
// glyph row per cycle is read from the single store port unless the output stalls;
// the first row goes via ST_BASE, ST_RUN, the rd_ stage and the output register.
// Reset is synchronous; surface width resets to 640, the glyph store is not cleared.
// An output stall holds the row pipeline; new words wait until all rows are issued.
`timescale 1ns / 1ps
module bitmap_glyph_blitter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbb_pkg::WIDTH_W-1:0]    cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // glyph_code, glyph_row, row_bits, text_row, text_column, pixel_color, pad
  input  logic [gbb_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic [0:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_address, write_mask, write_color, pad
  output logic [gbb_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);

  logic [gbb_pkg::WIDTH_W-1:0] width_r;
  gbb_pkg::gbb_mem_req_t       mem_req;
  logic [gbb_pkg::BITS_W-1:0]  mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= gbb_pkg::WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_r <= cfg_data;
    end
  end

  gbb_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .surface_width (width_r),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata)
  );

  gbb_glyph_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

// ===== rtl/gbb_glyph_ram.sv =====
// Glyph store: single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module gbb_glyph_ram (
  input  logic                       clk,
  input  gbb_pkg::gbb_mem_req_t      req,
  output logic [gbb_pkg::BITS_W-1:0] rdata
);

  logic [gbb_pkg::BITS_W-1:0] mem [gbb_pkg::STORE_DEPTH];
  logic [gbb_pkg::BITS_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/gbb_seq.sv =====
// Request decode, row sequencer, address generation and output register.
`timescale 1ns / 1ps
module gbb_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gbb_pkg::WIDTH_W-1:0]   surface_width,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [gbb_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [0:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [gbb_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast,
  output gbb_pkg::gbb_mem_req_t         mem_req,
  input  logic [gbb_pkg::BITS_W-1:0]    mem_rdata
);

  gbb_pkg::gbb_state_t state_r, state_nxt;

  logic [gbb_pkg::CODE_W-1:0]  in_code;
  logic [gbb_pkg::GROW_W-1:0]  in_grow;
  logic [gbb_pkg::BITS_W-1:0]  in_bits;
  logic [gbb_pkg::TROW_W-1:0]  in_trow;
  logic [gbb_pkg::TCOL_W-1:0]  in_tcol;
  logic [gbb_pkg::COLOR_W-1:0] in_color;

  logic [gbb_pkg::CODE_W-1:0]  code_r;
  logic [gbb_pkg::TROW_W-1:0]  trow_r;
  logic [gbb_pkg::TCOL_W-1:0]  tcol_r;
  logic [gbb_pkg::COLOR_W-1:0] color_r;
  logic [gbb_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [gbb_pkg::ROW_W-1:0]   y_r, y_nxt;

  logic                        rd_vld_r;
  logic [gbb_pkg::ADDR_W-1:0]  rd_addr_r;
  logic [gbb_pkg::COLOR_W-1:0] rd_color_r;
  logic                        rd_last_r;
  logic                        rd_ok_r;

  logic                        out_vld_r;
  logic [gbb_pkg::ADDR_W-1:0]  out_addr_r;
  logic [gbb_pkg::MASK_W-1:0]  out_mask_r;
  logic [gbb_pkg::COLOR_W-1:0] out_color_r;
  logic                        out_last_r;

  logic accept, is_load, code_ok, load_ok, rd_move, issue, y_last;
  logic [gbb_pkg::ADDR_W-1:0]   base_addr;
  logic [gbb_pkg::STORE_AW-1:0] load_addr, read_addr;

  assign in_code  = in_tdata[gbb_pkg::IN_GROW_LSB-1:gbb_pkg::IN_CODE_LSB];
  assign in_grow  = in_tdata[gbb_pkg::IN_BITS_LSB-1:gbb_pkg::IN_GROW_LSB];
  assign in_bits  = in_tdata[gbb_pkg::IN_TROW_LSB-1:gbb_pkg::IN_BITS_LSB];
  assign in_trow  = in_tdata[gbb_pkg::IN_TCOL_LSB-1:gbb_pkg::IN_TROW_LSB];
  assign in_tcol  = in_tdata[gbb_pkg::IN_COLOR_LSB-1:gbb_pkg::IN_TCOL_LSB];
  assign in_color = in_tdata[gbb_pkg::IN_COLOR_LSB+gbb_pkg::COLOR_W-1:gbb_pkg::IN_COLOR_LSB];

  assign in_tready = (state_r == gbb_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_load   = (in_tuser[0] == gbb_pkg::REQ_LOAD);
  assign load_ok   = ({1'b0, in_code} < (gbb_pkg::CODE_W+1)'(gbb_pkg::GLYPH_COUNT)) &&
                     ({1'b0, in_grow} < (gbb_pkg::GROW_W+1)'(gbb_pkg::GLYPH_HEIGHT));
  assign code_ok   = ({1'b0, code_r} < (gbb_pkg::CODE_W+1)'(gbb_pkg::GLYPH_COUNT));

  assign load_addr = gbb_pkg::STORE_AW'(in_code) * gbb_pkg::STORE_AW'(gbb_pkg::GLYPH_HEIGHT)
                   + gbb_pkg::STORE_AW'(in_grow);
  assign read_addr = gbb_pkg::STORE_AW'(code_r) * gbb_pkg::STORE_AW'(gbb_pkg::GLYPH_HEIGHT)
                   + gbb_pkg::STORE_AW'(y_r);

  assign base_addr = gbb_pkg::ADDR_W'(trow_r) * gbb_pkg::ADDR_W'(gbb_pkg::GLYPH_HEIGHT)
                   * gbb_pkg::ADDR_W'(surface_width)
                   + gbb_pkg::ADDR_W'(tcol_r) * gbb_pkg::ADDR_W'(gbb_pkg::GLYPH_WIDTH);

  assign rd_move = rd_vld_r && (!out_vld_r || out_tready);
  assign issue   = (state_r == gbb_pkg::ST_RUN) && (!rd_vld_r || rd_move);
  assign y_last  = (y_r == gbb_pkg::ROW_W'(gbb_pkg::GLYPH_HEIGHT - 1));

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    y_nxt         = y_r;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = read_addr;
    mem_req.wdata = in_bits;
    case (state_r)
      gbb_pkg::ST_IDLE: begin
        mem_req.addr = load_addr;
        if (accept) begin
          if (is_load) begin
            mem_req.we = load_ok;
          end else begin
            state_nxt = gbb_pkg::ST_BASE;
          end
        end
      end
      gbb_pkg::ST_BASE: begin
        addr_nxt  = base_addr;
        y_nxt     = '0;
        state_nxt = gbb_pkg::ST_RUN;
      end
      gbb_pkg::ST_RUN: begin
        if (issue) begin
          mem_req.re = 1'b1;
          addr_nxt   = addr_r + gbb_pkg::ADDR_W'(surface_width);
          y_nxt      = y_r + 1'b1;
          if (y_last) begin
            y_nxt     = '0;
            state_nxt = gbb_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = gbb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbb_pkg::ST_IDLE;
      y_r     <= '0;
    end else begin
      state_r <= state_nxt;
      y_r     <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (accept && !is_load) begin
      code_r  <= in_code;
      trow_r  <= in_trow;
      tcol_r  <= in_tcol;
      color_r <= in_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (issue) begin
      rd_vld_r <= 1'b1;
    end else if (rd_move) begin
      rd_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_addr_r  <= addr_r;
      rd_color_r <= color_r;
      rd_last_r  <= y_last;
      rd_ok_r    <= code_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rd_move) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_move) begin
      out_addr_r  <= rd_addr_r;
      out_mask_r  <= rd_ok_r ? gbb_pkg::row_mask(mem_rdata) : '0;
      out_color_r <= rd_color_r;
      out_last_r  <= rd_last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = gbb_pkg::OUT_DATA_W'({out_color_r, out_mask_r, out_addr_r});

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("glyph store written and read in one cycle");

  a_idle_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gbb_pkg::ST_IDLE |-> y_r == '0)
    else $error("row counter not cleared while idle");

  a_draw_to_base: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_load |=> state_r == gbb_pkg::ST_BASE)
    else $error("draw word did not start address setup");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    issue && y_last |=> state_r == gbb_pkg::ST_IDLE && rd_vld_r && rd_last_r)
    else $error("final row issue did not end the draw");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for bitmap_glyph_blitter_core: glyph loads, draws and width settings.
`timescale 1ns / 1ps
module testbench;
  import gbb_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [MASK_W-1:0]  mask;
    logic [COLOR_W-1:0] color;
    logic               last;
  } row_write_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [WIDTH_W-1:0]    cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  bitmap_glyph_blitter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  localparam int SETTLE_CYCLES = 24;
  localparam int WORD_TARGET   = 370;

  // glyph store mirror and width register mirror
  logic [BITS_W-1:0]  glyph_bytes [STORE_DEPTH];
  bit                 row_loaded  [STORE_DEPTH];
  bit                 glyph_drawable [GLYPH_COUNT];
  int                 drawable_codes [$];
  logic [WIDTH_W-1:0] surface_width = WIDTH_RESET;

  row_write_t expected_rows [$];

  int  error_count   = 0;
  int  words_sent    = 0;
  int  load_words    = 0;
  int  draw_words    = 0;
  int  rows_checked  = 0;
  int  in_gap_pct    = 0;
  int  out_stall_pct = 0;
  int  stall_left    = 0;
  bit  in_valid_owed = 0;

  always #5 clk = ~clk;

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      stall_left = pick_gap(out_stall_pct);
      out_tready <= (stall_left == 0);
    end
  end

  function automatic void queue_glyph_rows(input logic [CODE_W-1:0] code,
                                           input logic [TROW_W-1:0] trow,
                                           input logic [TCOL_W-1:0] tcol,
                                           input logic [COLOR_W-1:0] color);
    row_write_t        row;
    logic [63:0]       pix;
    logic [BITS_W-1:0] bits;
    int                b;
    for (int y = 0; y < GLYPH_HEIGHT; y++) begin
      bits = (code < GLYPH_COUNT) ? glyph_bytes[code * GLYPH_HEIGHT + y] : '0;
      pix = (64'(trow) * GLYPH_HEIGHT + 64'(y)) * 64'(surface_width)
          + 64'(tcol) * GLYPH_WIDTH;
      row.addr = pix[ADDR_W-1:0];
      row.mask = '0;
      for (int x = 0; x < MASK_W && x < GLYPH_WIDTH; x++) begin
        b = GLYPH_WIDTH - 1 - x;
        if (b < BITS_W) row.mask[MASK_W-1-x] = bits[b];
      end
      row.color = color;
      row.last  = (y == GLYPH_HEIGHT - 1);
      expected_rows.push_back(row);
    end
  endfunction

  function automatic void store_glyph_byte(input logic [CODE_W-1:0] code,
                                           input logic [GROW_W-1:0] grow,
                                           input logic [BITS_W-1:0] bits);
    bit complete;
    if (code >= GLYPH_COUNT || grow >= GLYPH_HEIGHT) return;
    glyph_bytes[code * GLYPH_HEIGHT + grow] = bits;
    row_loaded[code * GLYPH_HEIGHT + grow]  = 1'b1;
    complete = 1'b1;
    for (int y = 0; y < GLYPH_HEIGHT; y++)
      if (!row_loaded[code * GLYPH_HEIGHT + y]) complete = 1'b0;
    if (complete && !glyph_drawable[code]) begin
      glyph_drawable[code] = 1'b1;
      drawable_codes.push_back(code);
    end
  endfunction

  always @(posedge clk) begin
    row_write_t got;
    row_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.addr  = out_tdata[OUT_ADDR_LSB +: ADDR_W];
      got.mask  = out_tdata[OUT_MASK_LSB +: MASK_W];
      got.color = out_tdata[OUT_COLOR_LSB +: COLOR_W];
      got.last  = out_tlast;
      if (expected_rows.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word addr=%h mask=%h color=%h last=%b",
                 $realtime, got.addr, got.mask, got.color, got.last);
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (got.addr !== want.addr) begin
          error_count++;
          $display("%0t: pixel_address expected %h actual %h", $realtime, want.addr, got.addr);
        end
        if (got.mask !== want.mask) begin
          error_count++;
          $display("%0t: write_mask expected %h actual %h", $realtime, want.mask, got.mask);
        end
        if (got.color !== want.color) begin
          error_count++;
          $display("%0t: write_color expected %h actual %h", $realtime, want.color, got.color);
        end
        if (got.last !== want.last) begin
          error_count++;
          $display("%0t: last_row expected %b actual %b", $realtime, want.last, got.last);
        end
      end
    end
  end

  task automatic send_word(input logic req, input logic [CODE_W-1:0] code,
                           input logic [GROW_W-1:0] grow, input logic [BITS_W-1:0] bits,
                           input logic [TROW_W-1:0] trow, input logic [TCOL_W-1:0] tcol,
                           input logic [COLOR_W-1:0] color);
    int gap;
    gap = pick_gap(in_gap_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {1'b0, color, tcol, trow, bits, grow, code};
    do @(posedge clk); while (!in_tready);
    in_valid_owed = 1'b1;
    words_sent++;
    if (req == REQ_LOAD) begin
      load_words++;
      store_glyph_byte(code, grow, bits);
    end else begin
      draw_words++;
      queue_glyph_rows(code, trow, tcol, color);
    end
  endtask

  // drop valid, then hold until every row has come and the core has settled
  task automatic drain;
    if (in_valid_owed) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_valid_owed = 1'b0;
    end
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [WIDTH_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    surface_width = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_glyph(input logic [CODE_W-1:0] code);
    for (int y = 0; y < GLYPH_HEIGHT; y++)
      send_word(REQ_LOAD, code, GROW_W'(y), BITS_W'($urandom), TROW_W'($urandom),
                TCOL_W'($urandom), $urandom);
  endtask

  task automatic draw_random(input logic [CODE_W-1:0] code);
    logic [TROW_W-1:0]  trow;
    logic [TCOL_W-1:0]  tcol;
    trow = ($urandom_range(0, 4) == 0) ? '1 : TROW_W'($urandom);
    tcol = ($urandom_range(0, 4) == 0) ? '1 : TCOL_W'($urandom);
    send_word(REQ_DRAW, code, GROW_W'($urandom), BITS_W'($urandom), trow, tcol, $urandom);
  endtask

  task automatic test_glyph_load_and_draw;
    logic [BITS_W-1:0] pattern [4] = '{8'hFF, 8'h00, 8'h80, 8'h01};
    for (int y = 0; y < GLYPH_HEIGHT; y++)
      send_word(REQ_LOAD, 8'hFF, GROW_W'(y),
                (y < 4) ? pattern[y] : BITS_W'($urandom), '1, '1, '1);
    send_word(REQ_DRAW, 8'hFF, '0, '0, '0, '0, '0);
    send_word(REQ_DRAW, 8'hFF, '1, '1, '1, '1, '1);
  endtask

  task automatic test_width_extremes;
    logic [WIDTH_W-1:0] widths [4] = '{14'd0, 14'd1, 14'd8192, 14'h3FFF};
    for (int i = 0; i < 4; i++) begin
      write_width(widths[i]);
      send_word(REQ_DRAW, 8'hFF, '0, '0, '1, '1, (i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0);
    end
  endtask

  task automatic test_random_traffic;
    int r;
    int phase_end;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_width(WIDTH_W'($urandom_range(1, 8192))); in_gap_pct = 30;
                 out_stall_pct = 30; end
        1: begin write_width(WIDTH_W'($urandom_range(1, 8192))); in_gap_pct = 0;
                 out_stall_pct = 0; end
        2: begin write_width(14'h3FFF); in_gap_pct = 60; out_stall_pct = 50; end
        default: begin write_width(WIDTH_RESET); in_gap_pct = 15; out_stall_pct = 15; end
      endcase
      phase_end = words_sent + (WORD_TARGET - words_sent) / (4 - phase);
      while (words_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (drawable_codes.size() == 0 || r < 15)
          load_glyph(CODE_W'($urandom));
        else if (r < 25)
          send_word(REQ_LOAD, CODE_W'($urandom), GROW_W'($urandom), BITS_W'($urandom),
                    TROW_W'($urandom), TCOL_W'($urandom), $urandom);
        else
          draw_random(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)]);
        if ($urandom_range(0, 99) < 3) drain();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_glyph_load_and_draw();
    test_width_extremes();
    test_random_traffic();
    drain();
    if (expected_rows.size() != 0) begin
      error_count += expected_rows.size();
      $display("%0t: %0d result words never arrived", $realtime, expected_rows.size());
    end
    $display("Covered %0d load and %0d draw words, %0d row words checked.",
             load_words, draw_words, rows_checked);
    $display("Surface widths 0, 1, 640, 8192, 16383 and random, with and without stalls.");
    if (error_count == 0) begin
      $display("bitmap_glyph_blitter_core verification clean");
    end else begin
      $display("bitmap_glyph_blitter_core verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $realtime);
    $display("bitmap_glyph_blitter_core verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gbb_pkg.sv
rtl/gbb_glyph_ram.sv
rtl/gbb_seq.sv
rtl/bitmap_glyph_blitter_core.sv
tb/testbench.sv
